>>> rtl/core/b64d_pkg.sv
// Shared types, constants and the character classifier of the Base64 stream decoder.
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_LENGTH  = 2'd1;
	localparam logic [1:0] STATUS_BADCHAR = 2'd2;

	// One job handed from the front to the back: a decoded group or a length error.
	typedef struct packed {
		logic [23:0] triple;
		logic [1:0]  nbytes;
		logic        final_quad;
		logic        bad_char;
		logic        len_err;
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] sextet;
	} sextet_t;

	// Maps one ASCII character to its sextet; pad maps to zero and is valid.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok     = 1'b1;
		r.sextet = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.sextet = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.sextet = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.sextet = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.sextet = 6'd62;
		end else if (c == 8'h2F) begin
			r.sextet = 6'd63;
		end else if (c != PAD_CHAR) begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/b64d_front.sv
// Front end: classifies each character, gathers quads and issues decode jobs.
module b64d_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    char_in,
	input  logic          message_end,
	output logic          job_push,
	output b64d_pkg::job_t job
);
	import b64d_pkg::*;

	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic        third_pad_q;
	logic        bad_q;

	sextet_t     sx;
	logic        is_pad;
	logic        bad_now;
	logic [1:0]  drop;

	assign sx      = sextet_of(char_in);
	assign is_pad  = (char_in == PAD_CHAR);
	assign bad_now = bad_q | ~sx.ok;
	assign drop    = 2'(message_end & is_pad) + 2'(message_end & third_pad_q);

	always_comb begin
		job            = '0;
		job_push       = 1'b0;
		job.triple     = {acc_q, sx.sextet};
		job.nbytes     = 2'd3 - drop;
		job.final_quad = message_end;
		job.bad_char   = bad_now;
		if (accept) begin
			if (pos_q == 2'd3) begin
				job_push = 1'b1;
			end else if (message_end) begin
				job_push    = 1'b1;
				job.len_err = 1'b1;
				job.triple  = '0;
				job.nbytes  = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			acc_q       <= '0;
			third_pad_q <= 1'b0;
			bad_q       <= 1'b0;
		end else if (accept) begin
			if (pos_q == 2'd3 || message_end) begin
				pos_q       <= '0;
				acc_q       <= '0;
				third_pad_q <= 1'b0;
				bad_q       <= message_end ? 1'b0 : bad_now;
			end else begin
				pos_q <= pos_q + 2'd1;
				acc_q <= {acc_q[11:0], sx.sextet};
				bad_q <= bad_now;
				if (pos_q == 2'd2) begin
					third_pad_q <= is_pad;
				end
			end
		end
	end

endmodule

>>> rtl/core/b64d_queue.sv
// Small job queue between the front and back ends.
module b64d_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output b64d_pkg::job_t head
);
	import b64d_pkg::*;

	job_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/b64d_back.sv
// Back end: splits each job into output words and holds the output register.
module b64d_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  b64d_pkg::job_t job,
	output logic           job_pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [7:0]     m_axis_tdata,
	output logic           m_axis_tlast,
	output logic [3:0]     m_axis_tuser
);
	import b64d_pkg::*;

	logic [1:0] idx_q;
	logic       load;
	logic       word_last;
	logic [7:0] word_byte;
	logic       word_valid;
	logic       word_eom;
	logic [1:0] word_status;

	assign load      = job_valid && (!m_axis_tvalid || m_axis_tready);
	assign word_last = job.len_err || (idx_q == job.nbytes - 2'd1);
	assign job_pop   = load && word_last;

	always_comb begin
		word_byte   = '0;
		word_valid  = 1'b1;
		word_eom    = job.final_quad && word_last;
		word_status = STATUS_OK;
		case (idx_q)
			2'd0:    word_byte = job.triple[23:16];
			2'd1:    word_byte = job.triple[15:8];
			default: word_byte = job.triple[7:0];
		endcase
		if (job.len_err) begin
			word_byte   = '0;
			word_valid  = 1'b0;
			word_eom    = 1'b1;
			word_status = STATUS_LENGTH;
		end else if (word_eom && job.bad_char) begin
			word_status = STATUS_BADCHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			idx_q         <= '0;
		end else if (load) begin
			m_axis_tvalid <= 1'b1;
			idx_q         <= word_last ? 2'd0 : idx_q + 2'd1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_axis_tdata <= word_byte;
			m_axis_tlast <= word_last;
			m_axis_tuser <= {word_status, word_eom, word_valid};
		end
	end

endmodule

>>> rtl/core/base64_stream_decoder_unit.sv
// Top level of the Base64 stream decoder.
// The block takes one Base64 character per word and accepts a new word on
// every clock cycle as long as its internal job queue has room, so a steady
// stream runs at one character per cycle. The front end classifies each
// character, gathers four sextets into a 24-bit group and, on the fourth
// character or on the message's last one, writes a job into a four-entry
// queue. The back end turns each job into one to three output words, one
// word per cycle while the output is ready, through a registered output
// stage; a finished word waits there while new characters keep flowing in.
// Since four characters yield at most three bytes, the back end keeps up
// with a full-rate input unless the output side stalls; the queue then
// absorbs short stalls and fills up before input backpressure appears. A
// completed group's job is written into the queue and its words then pass
// through the output register. In the final group a trailing pad drops one
// byte and a pad in the second-to-last place drops another. A message that ends
// off a group boundary gives a single word flagged invalid with the length
// status, and a character outside the alphabet decodes as zero and sets the
// bad-character status on the message's final word unless it holds the length
// status. After the final word the decoder starts the next message fresh.
module base64_stream_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] char_in
	input  logic       s_axis_tlast,  // message_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] data_byte
	output logic       m_axis_tlast,  // last_of_run
	output logic [3:0] m_axis_tuser   // [0] byte_valid, [1] end_of_message, [3:2] status
);
	import b64d_pkg::*;

	logic accept;
	logic job_push;
	job_t push_job;
	logic q_full;
	logic q_not_empty;
	job_t head_job;
	logic job_pop;

	// The front end never stalls on its own; only a full queue holds input off.
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_in     (s_axis_tdata),
		.message_end (s_axis_tlast),
		.job_push    (job_push),
		.job         (push_job)
	);

	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (push_job),
		.pop       (job_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_job)
	);

	// The back end pops a job only when its last word moves into the output register.
	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (q_not_empty),
		.job           (head_job),
		.job_pop       (job_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
